@@ rtl/ter_pkg.sv @@
// ----------------------------------------------------------------------------
// ter_pkg
// Shared types and constants for the triangle edge rasterizer: transaction
// payloads, operation codes and the edge arithmetic widths.
// ----------------------------------------------------------------------------
package ter_pkg;

    // coordinate and derived widths
    localparam int C_COORD_BITS = 12;
    localparam int C_STEP_BITS  = C_COORD_BITS + 1;
    localparam int C_PROD_BITS  = 2 * C_COORD_BITS + 2;
    localparam int C_EDGE_BITS  = 2 * C_COORD_BITS + 4;
    localparam int C_COLOR_BITS = 32;
    localparam int C_NUM_EDGES  = 3;

    // operation codes
    localparam logic C_OP_START = 1'b0;
    localparam logic C_OP_STEP  = 1'b1;

    typedef logic [C_COORD_BITS-1:0]        t_coord;
    typedef logic signed [C_STEP_BITS-1:0]  t_step;
    typedef logic signed [C_PROD_BITS-1:0]  t_prod;
    typedef logic signed [C_EDGE_BITS-1:0]  t_edge;

    // input transaction
    typedef struct packed {
        logic                    op;
        t_coord                  vertex_ax;
        t_coord                  vertex_ay;
        t_coord                  vertex_bx;
        t_coord                  vertex_by;
        t_coord                  vertex_cx;
        t_coord                  vertex_cy;
        logic [C_COLOR_BITS-1:0] fill_color_in;
    } t_in_item;

    // output transaction
    typedef struct packed {
        t_coord                  pixel_x;
        t_coord                  pixel_y;
        logic                    covered;
        logic [C_COLOR_BITS-1:0] pixel_color;
        logic                    position_valid;
        logic                    last_in_box;
    } t_out_item;

endpackage

@@ rtl/triangle_edge_rasterizer_top.sv @@
// ----------------------------------------------------------------------------
// triangle_edge_rasterizer_top
// Half-space edge function rasterizer: a start transaction loads a triangle,
// each step transaction reports the next bounding box position and coverage.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------
//   in      | input     | i_in_valid/o_in_stall   | t_in_item
//   out     | output    | o_out_valid/i_out_stall | t_out_item
//
// Steps may follow back to back while the input is not stalled; each
// yields one result in the cycle after acceptance. A start loads the
// triangle, then in the following cycle forms a seed for each triangle edge through
// the edge multipliers while the input is stalled. A start yields no result.
// Reset (synchronous, active low) drops any triangle and any pending result.
// A valid output register is held while i_out_stall is high; the input is then
// stalled as well.
// ----------------------------------------------------------------------------
module triangle_edge_rasterizer_top
    import ter_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    // triangle state
    t_coord r_box_left,   n_box_left;
    t_coord r_box_right,  n_box_right;
    t_coord r_box_bottom, n_box_bottom;
    t_coord r_cursor_x,   n_cursor_x;
    t_coord r_cursor_y,   n_cursor_y;
    t_edge  r_row_edge   [C_NUM_EDGES];
    t_edge  n_row_edge   [C_NUM_EDGES];
    t_edge  r_pixel_edge [C_NUM_EDGES];
    t_edge  n_pixel_edge [C_NUM_EDGES];
    t_step  r_step_dx    [C_NUM_EDGES];
    t_step  n_step_dx    [C_NUM_EDGES];
    t_step  r_step_dy    [C_NUM_EDGES];
    t_step  n_step_dy    [C_NUM_EDGES];
    t_step  r_ofs_x      [C_NUM_EDGES];
    t_step  n_ofs_x      [C_NUM_EDGES];
    t_step  r_ofs_y      [C_NUM_EDGES];
    t_step  n_ofs_y      [C_NUM_EDGES];
    logic [C_COLOR_BITS-1:0] r_color, n_color;
    logic   r_busy, n_busy;
    logic   r_seed_pending, n_seed_pending;

    // output register
    logic      r_out_valid, n_out_valid;
    t_out_item r_out_data,  n_out_data;

    logic   w_in_acc;
    logic   w_start;
    logic   w_step;
    t_coord w_vx [C_NUM_EDGES];
    t_coord w_vy [C_NUM_EDGES];
    t_coord w_min_x, w_max_x, w_min_y, w_max_y;
    t_prod  w_prod_x [C_NUM_EDGES];
    t_prod  w_prod_y [C_NUM_EDGES];
    logic   w_cov;
    logic   w_row_end;
    logic   w_box_end;

    // handshake
    assign o_in_stall  = r_seed_pending || (r_out_valid && i_out_stall);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_start     = w_in_acc && (i_in_data.op == C_OP_START);
    assign w_step      = w_in_acc && (i_in_data.op == C_OP_STEP);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // gather vertices per edge origin
    assign w_vx[0] = i_in_data.vertex_ax;
    assign w_vy[0] = i_in_data.vertex_ay;
    assign w_vx[1] = i_in_data.vertex_bx;
    assign w_vy[1] = i_in_data.vertex_by;
    assign w_vx[2] = i_in_data.vertex_cx;
    assign w_vy[2] = i_in_data.vertex_cy;

    // bounding box
    always_comb begin
        w_min_x = (w_vx[0] < w_vx[1]) ? w_vx[0] : w_vx[1];
        w_min_x = (w_min_x < w_vx[2]) ? w_min_x : w_vx[2];
        w_max_x = (w_vx[0] > w_vx[1]) ? w_vx[0] : w_vx[1];
        w_max_x = (w_max_x > w_vx[2]) ? w_max_x : w_vx[2];
        w_min_y = (w_vy[0] < w_vy[1]) ? w_vy[0] : w_vy[1];
        w_min_y = (w_min_y < w_vy[2]) ? w_min_y : w_vy[2];
        w_max_y = (w_vy[0] > w_vy[1]) ? w_vy[0] : w_vy[1];
        w_max_y = (w_max_y > w_vy[2]) ? w_max_y : w_vy[2];
    end

    // seed products from the registered deltas and corner offsets
    always_comb begin
        for (int i = 0; i < C_NUM_EDGES; i++) begin
            w_prod_x[i] = t_prod'(r_step_dx[i]) * t_prod'(r_ofs_y[i]);
            w_prod_y[i] = t_prod'(r_step_dy[i]) * t_prod'(r_ofs_x[i]);
        end
    end

    // coverage and traversal position
    assign w_cov = (r_pixel_edge[0] > 0) && (r_pixel_edge[1] > 0) && (r_pixel_edge[2] > 0);
    assign w_row_end = ({1'b0, r_cursor_x} + (C_COORD_BITS + 1)'(1)) >= {1'b0, r_box_right};
    assign w_box_end = w_row_end &&
                       (({1'b0, r_cursor_y} + (C_COORD_BITS + 1)'(1)) >= {1'b0, r_box_bottom});

    // next triangle state
    always_comb begin
        n_box_left     = r_box_left;
        n_box_right    = r_box_right;
        n_box_bottom   = r_box_bottom;
        n_cursor_x     = r_cursor_x;
        n_cursor_y     = r_cursor_y;
        n_row_edge     = r_row_edge;
        n_pixel_edge   = r_pixel_edge;
        n_step_dx      = r_step_dx;
        n_step_dy      = r_step_dy;
        n_ofs_x        = r_ofs_x;
        n_ofs_y        = r_ofs_y;
        n_color        = r_color;
        n_busy         = r_busy;
        n_seed_pending = 1'b0;

        if (w_start) begin
            // load box, deltas and corner offsets; seeds follow next cycle
            n_box_left   = w_min_x;
            n_box_right  = w_max_x;
            n_box_bottom = w_max_y;
            n_cursor_x   = w_min_x;
            n_cursor_y   = w_min_y;
            n_color      = i_in_data.fill_color_in;
            n_busy       = (w_min_x < w_max_x) && (w_min_y < w_max_y);
            for (int i = 0; i < C_NUM_EDGES; i++) begin
                n_step_dx[i] = $signed({1'b0, w_vx[(i + 1) % C_NUM_EDGES]})
                             - $signed({1'b0, w_vx[i]});
                n_step_dy[i] = $signed({1'b0, w_vy[(i + 1) % C_NUM_EDGES]})
                             - $signed({1'b0, w_vy[i]});
                n_ofs_x[i]   = $signed({1'b0, w_min_x}) - $signed({1'b0, w_vx[i]});
                n_ofs_y[i]   = $signed({1'b0, w_min_y}) - $signed({1'b0, w_vy[i]});
            end
            n_seed_pending = 1'b1;
        end else if (w_step && r_busy) begin
            // advance one column, or wrap to the next row
            if (w_row_end) begin
                for (int i = 0; i < C_NUM_EDGES; i++) begin
                    n_row_edge[i]   = r_row_edge[i] + C_EDGE_BITS'(r_step_dx[i]);
                    n_pixel_edge[i] = r_row_edge[i] + C_EDGE_BITS'(r_step_dx[i]);
                end
                n_cursor_x = r_box_left;
                n_cursor_y = r_cursor_y + t_coord'(1);
                n_busy     = !w_box_end;
            end else begin
                for (int i = 0; i < C_NUM_EDGES; i++) begin
                    n_pixel_edge[i] = r_pixel_edge[i] - C_EDGE_BITS'(r_step_dy[i]);
                end
                n_cursor_x = r_cursor_x + t_coord'(1);
            end
        end

        // write edge seeds at the box corner
        if (r_seed_pending) begin
            for (int i = 0; i < C_NUM_EDGES; i++) begin
                n_row_edge[i]   = C_EDGE_BITS'(w_prod_x[i]) - C_EDGE_BITS'(w_prod_y[i]);
                n_pixel_edge[i] = C_EDGE_BITS'(w_prod_x[i]) - C_EDGE_BITS'(w_prod_y[i]);
            end
        end
    end

    // next output transaction
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        if (w_step) begin
            n_out_valid = 1'b1;
            if (r_busy) begin
                n_out_data.pixel_x        = r_cursor_x;
                n_out_data.pixel_y        = r_cursor_y;
                n_out_data.covered        = w_cov;
                n_out_data.pixel_color    = r_color;
                n_out_data.position_valid = 1'b1;
                n_out_data.last_in_box    = w_box_end;
            end else begin
                n_out_data.pixel_x        = '0;
                n_out_data.pixel_y        = '0;
                n_out_data.covered        = 1'b0;
                n_out_data.pixel_color    = '0;
                n_out_data.position_valid = 1'b0;
                n_out_data.last_in_box    = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy         <= 1'b0;
            r_seed_pending <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_busy         <= n_busy;
            r_seed_pending <= n_seed_pending;
            r_out_valid    <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_box_left   <= n_box_left;
        r_box_right  <= n_box_right;
        r_box_bottom <= n_box_bottom;
        r_cursor_x   <= n_cursor_x;
        r_cursor_y   <= n_cursor_y;
        r_row_edge   <= n_row_edge;
        r_pixel_edge <= n_pixel_edge;
        r_step_dx    <= n_step_dx;
        r_step_dy    <= n_step_dy;
        r_ofs_x      <= n_ofs_x;
        r_ofs_y      <= n_ofs_y;
        r_color      <= n_color;
        r_out_data   <= n_out_data;
    end

    // checks
    a_start_seeds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> r_seed_pending)
        else $error("start transaction did not schedule edge seeds");

    a_seed_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seed_pending |-> o_in_stall)
        else $error("input accepted while edge seeds pending");

    a_step_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> o_out_valid)
        else $error("step transaction produced no result");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.position_valid) |-> o_out_data.last_in_box)
        else $error("empty result not flagged as last in box");

endmodule
